// ----- design/switch_debounce_edge_latch_core_defines.svh -----
// Assertion macros shared by the switch debouncer RTL.
// No dependencies; included by the top level, which carries the assertions.
`ifndef SWITCH_DEBOUNCE_EDGE_LATCH_CORE_DEFINES_SVH
`define SWITCH_DEBOUNCE_EDGE_LATCH_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SDEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SDEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDEL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SDEL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/sdel_pkg.sv -----
// Package for the switch debouncer: widths, reset values, register codes,
// the per-lane result struct and the lockout reload function. No dependencies.
`timescale 1ns / 1ps

package sdel_pkg;

    localparam int unsigned SWITCH_COUNT_DEF = 16;
    localparam int unsigned FIELD_W          = 16;
    localparam int unsigned LOCKOUT_W        = 10;
    localparam int unsigned APB_ADDR_W       = 3;
    localparam int unsigned APB_DATA_W       = 32;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET  = LOCKOUT_W'(100);
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_MAX    = '1;
    localparam logic [FIELD_W-1:0]   IRQ_MASK_RESET = 16'hC302;

    typedef enum logic {
        REG_LOCKOUT  = 1'b0,
        REG_IRQ_MASK = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic level;   // debounced level after the request
        logic got;     // latched press read out by this request
        logic press;   // press accepted by this request
    } t_lane_res;

    // lockout_ticks + 1, held at the counter's top value
    function automatic logic [LOCKOUT_W-1:0] sat_reload(input logic [LOCKOUT_W-1:0] ticks);
        logic [LOCKOUT_W:0] sum;
        sum = {1'b0, ticks} + {{LOCKOUT_W{1'b0}}, 1'b1};
        sat_reload = sum[LOCKOUT_W] ? LOCKOUT_MAX : sum[LOCKOUT_W-1:0];
    endfunction

endpackage

// ----- design/sdel_lane.sv -----
// One switch lane: lockout counter, debounced level and press latch.
// Depends on sdel_pkg.
`timescale 1ns / 1ps

module sdel_lane #(
    parameter int unsigned CNT_W = sdel_pkg::LOCKOUT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_pressed,
    input  logic                i_tick,
    input  logic                i_read,
    input  logic [CNT_W-1:0]    i_reload,
    output sdel_pkg::t_lane_res o_res
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_level, n_level;
    logic             r_latch, n_latch;
    logic [CNT_W-1:0] cnt_dec;
    logic             open_win;
    logic             press;
    logic             release_sw;
    logic             latch_upd;

    always_comb begin
        // count down first, then look at the level
        cnt_dec    = (i_tick && (r_cnt != '0)) ? (r_cnt - CNT_W'(1)) : r_cnt;
        open_win   = (cnt_dec == '0);
        press      = open_win && i_pressed && !r_level;
        release_sw = open_win && !i_pressed && r_level;

        n_level   = press ? 1'b1 : (release_sw ? 1'b0 : r_level);
        latch_upd = press ? 1'b1 : (release_sw ? 1'b0 : r_latch);
        n_latch   = latch_upd & ~i_read;
        n_cnt     = (press || release_sw) ? i_reload : cnt_dec;

        o_res.level = n_level;
        o_res.got   = latch_upd & i_read;
        o_res.press = press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_level <= 1'b0;
            r_latch <= 1'b0;
        end else if (i_fire) begin
            r_cnt   <= n_cnt;
            r_level <= n_level;
            r_latch <= n_latch;
        end
    end

endmodule

// ----- design/sdel_merge.sv -----
// Merge stage: gathers the lane results into the result fields, applies the
// interrupt mask and holds the result in the output register. Depends on sdel_pkg.
`timescale 1ns / 1ps

module sdel_merge #(
    parameter int unsigned LANES = sdel_pkg::SWITCH_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  sdel_pkg::t_lane_res         i_lane [LANES],
    input  logic [sdel_pkg::FIELD_W-1:0] i_irq_mask,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output logic [sdel_pkg::FIELD_W-1:0] o_levels,
    output logic [sdel_pkg::FIELD_W-1:0] o_presses,
    output logic [sdel_pkg::FIELD_W-1:0] o_irqs
);

    localparam int unsigned FW = sdel_pkg::FIELD_W;

    logic [FW-1:0] lvl_vec, got_vec, prs_vec;
    logic          r_valid;
    logic [FW-1:0] r_levels, r_presses, r_irqs;

    for (genvar g = 0; g < FW; g++) begin : g_pack
        if (g < LANES) begin : g_live
            assign lvl_vec[g] = i_lane[g].level;
            assign got_vec[g] = i_lane[g].got;
            assign prs_vec[g] = i_lane[g].press;
        end else begin : g_absent
            assign lvl_vec[g] = 1'b0;
            assign got_vec[g] = 1'b0;
            assign prs_vec[g] = 1'b0;
        end
    end

    // take a new request when nothing is held or the held result leaves this cycle
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_levels  <= lvl_vec;
            r_presses <= got_vec;
            r_irqs    <= prs_vec & i_irq_mask;
        end
    end

    assign o_out_valid = r_valid;
    assign o_levels    = r_levels;
    assign o_presses   = r_presses;
    assign o_irqs      = r_irqs;

endmodule

// ----- design/switch_debounce_edge_latch_core.sv -----
// Top level of the lockout switch debouncer: stream ports, APB registers,
// one lane per switch and the merge stage. Depends on sdel_pkg, sdel_lane,
// sdel_merge and switch_debounce_edge_latch_core_defines.svh.
//
//  Port group   Dir   Content (low bits first)
//  s_axis_*     in    tdata: pressed[15:0], tick[16], read_mask[32:17]
//  m_axis_*     out   tdata: debounced_levels[15:0], new_presses[31:16],
//                            irq_requests[47:32]
//  APB          in    0x0 lockout_ticks, 0x4 irq_switch_mask
//
// One request per cycle while s_axis_tready is high; its result appears in the output
// register in the cycle after it is accepted. All lanes update in the same cycle.
// Reset (synchronous): lockout counters, levels and latches cleared,
// lockout_ticks = 100, irq_switch_mask = 0xC302.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
`timescale 1ns / 1ps
`include "switch_debounce_edge_latch_core_defines.svh"

module switch_debounce_edge_latch_core #(
    parameter int unsigned SWITCH_COUNT = sdel_pkg::SWITCH_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pressed[15:0], tick[16], read_mask[32:17], zero[39:33]
    input  logic [39:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // debounced_levels[15:0], new_presses[31:16], irq_requests[47:32]
    output logic [47:0]                     m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdel_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sdel_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sdel_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int unsigned FW    = sdel_pkg::FIELD_W;
    localparam int unsigned CW    = sdel_pkg::LOCKOUT_W;
    localparam int unsigned DW    = sdel_pkg::APB_DATA_W;
    localparam int unsigned LANES = (SWITCH_COUNT > FW) ? FW : SWITCH_COUNT;

    logic [CW-1:0]       r_lockout_ticks;
    logic [FW-1:0]       r_irq_mask;
    logic                cfg_wr;
    sdel_pkg::t_reg_idx  reg_idx;
    logic [CW-1:0]       reload;
    logic                s_fire;
    logic [FW-1:0]       in_pressed;
    logic                in_tick;
    logic [FW-1:0]       in_read;
    sdel_pkg::t_lane_res lane_res [LANES];
    logic [FW-1:0]       out_levels, out_presses, out_irqs;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = sdel_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ticks <= sdel_pkg::LOCKOUT_RESET;
            r_irq_mask      <= sdel_pkg::IRQ_MASK_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sdel_pkg::REG_LOCKOUT:  r_lockout_ticks <= pwdata[CW-1:0];
                sdel_pkg::REG_IRQ_MASK: r_irq_mask      <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sdel_pkg::REG_LOCKOUT:  prdata = DW'(r_lockout_ticks);
            sdel_pkg::REG_IRQ_MASK: prdata = DW'(r_irq_mask);
            default:                prdata = '0;
        endcase
    end

    assign reload = sdel_pkg::sat_reload(r_lockout_ticks);

    // request fields
    assign in_pressed = s_axis_tdata[FW-1:0];
    assign in_tick    = s_axis_tdata[FW];
    assign in_read    = s_axis_tdata[2*FW:FW+1];
    assign s_fire     = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sdel_lane #(
            .CNT_W (CW)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_fire    (s_fire),
            .i_pressed (in_pressed[g]),
            .i_tick    (in_tick),
            .i_read    (in_read[g]),
            .i_reload  (reload),
            .o_res     (lane_res[g])
        );
    end

    sdel_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s_fire),
        .i_lane      (lane_res),
        .i_irq_mask  (r_irq_mask),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_levels    (out_levels),
        .o_presses   (out_presses),
        .o_irqs      (out_irqs)
    );

    assign m_axis_tdata = {out_irqs, out_presses, out_levels};

    // an accepted request always leaves a result behind
    `SDEL_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, s_fire, m_axis_tvalid)
    // an idle output never holds off the input
    `SDEL_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    // an interrupt is only raised for a switch that is now pressed
    `SDEL_ASSERT_NOW(a_irq_in_levels, i_clk, i_rst_n, m_axis_tvalid, (out_irqs & ~out_levels) == '0)
    // a latched press only survives while its switch stays pressed
    `SDEL_ASSERT_NOW(a_got_in_levels, i_clk, i_rst_n, m_axis_tvalid, (out_presses & ~out_levels) == '0)

endmodule

// ----- tb/sv/tb_switch_debounce_edge_latch_core.sv -----
// Self-checking testbench for switch_debounce_edge_latch_core: a directed table,
// then randomized phases under several lockout and irq mask settings.
// Depends on sdel_pkg and the debouncer RTL; checks every result against the table or a local predictor.
`timescale 1ns / 1ps

module tb_switch_debounce_edge_latch_core;

    localparam int unsigned FIELD_W    = sdel_pkg::FIELD_W;
    localparam int unsigned LOCKOUT_W  = sdel_pkg::LOCKOUT_W;
    localparam int unsigned APB_ADDR_W = sdel_pkg::APB_ADDR_W;
    localparam int unsigned APB_DATA_W = sdel_pkg::APB_DATA_W;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_MAX    = sdel_pkg::LOCKOUT_MAX;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET  = sdel_pkg::LOCKOUT_RESET;
    localparam logic [FIELD_W-1:0]   IRQ_MASK_RESET = sdel_pkg::IRQ_MASK_RESET;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_ITEMS  = 234;

    // one result, laid out as on m_axis_tdata (levels in the low bits)
    typedef struct packed {
        logic [FIELD_W-1:0] irq;
        logic [FIELD_W-1:0] got;
        logic [FIELD_W-1:0] levels;
    } t_panel;

    typedef enum logic {
        ROW_REQ,
        ROW_REG
    } t_plan_kind;

    typedef struct {
        t_plan_kind         kind;
        sdel_pkg::t_reg_idx idx;
        logic [31:0]        value;
        logic [FIELD_W-1:0] raw;
        logic               tick;
        logic [FIELD_W-1:0] rmask;
        bit                 typed;
        t_panel             want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // pressed[15:0], tick[16], read_mask[32:17], zero[39:33]
    logic [39:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // debounced_levels[15:0], new_presses[31:16], irq_requests[47:32]
    logic [47:0]           m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [LOCKOUT_W-1:0] lock_left [FIELD_W];
    logic [FIELD_W-1:0]   deb_levels;
    logic [FIELD_W-1:0]   press_held;
    logic [LOCKOUT_W-1:0] lockout_cfg;
    logic [FIELD_W-1:0]   irq_cfg;

    t_panel expected_panels [$];
    int     mismatches;
    int     requests_sent;
    int     panels_checked;
    int     irq_panels;
    int     reg_writes;
    int     holds_done;
    int     send_gap_pct;
    int     cycle_count;

    switch_debounce_edge_latch_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Count down, accept changes on unlocked switches, then read out latched presses.
    function automatic t_panel advance_panel(input logic [FIELD_W-1:0] raw, input logic tick,
                                             input logic [FIELD_W-1:0] rmask);
        t_panel               r;
        logic [FIELD_W-1:0]   accepted;
        logic [LOCKOUT_W-1:0] reload;
        reload   = (lockout_cfg == LOCKOUT_MAX) ? LOCKOUT_MAX : lockout_cfg + 1'b1;
        accepted = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (tick && lock_left[i] != 0)
                lock_left[i] = lock_left[i] - 1'b1;
            if (lock_left[i] == 0 && raw[i] != deb_levels[i]) begin
                deb_levels[i] = raw[i];
                press_held[i] = raw[i];
                accepted[i]   = raw[i];
                lock_left[i]  = reload;
            end
        end
        r.got      = press_held & rmask;
        press_held = press_held & ~rmask;
        r.levels   = deb_levels;
        r.irq      = accepted & irq_cfg;
        return r;
    endfunction

    function automatic t_plan_row req_row(input logic [FIELD_W-1:0] raw, input logic tick,
                                          input logic [FIELD_W-1:0] rmask, input bit typed,
                                          input logic [FIELD_W-1:0] levels,
                                          input logic [FIELD_W-1:0] got,
                                          input logic [FIELD_W-1:0] irq);
        t_plan_row r;
        r.kind  = ROW_REQ;
        r.idx   = sdel_pkg::REG_LOCKOUT;
        r.value = '0;
        r.raw   = raw;
        r.tick  = tick;
        r.rmask = rmask;
        r.typed = typed;
        r.want  = {irq, got, levels};
        return r;
    endfunction

    function automatic t_plan_row reg_row(input sdel_pkg::t_reg_idx idx,
                                          input logic [31:0] value);
        t_plan_row r;
        r       = req_row('0, 1'b0, '0, 1'b0, '0, '0, '0);
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] seen);
        if (seen !== want) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, want, seen);
        end
    endfunction

    task automatic read_reg(input sdel_pkg::t_reg_idx idx, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want) begin
            mismatches++;
            $display("%0t: %s readback expected %h got %h", $time, idx.name(), want, prdata);
        end
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input sdel_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sdel_pkg::REG_LOCKOUT)
            lockout_cfg = value[LOCKOUT_W-1:0];
        else
            irq_cfg = value[FIELD_W-1:0];
        reg_writes++;
        read_reg(idx, (idx == sdel_pkg::REG_LOCKOUT) ? 32'(lockout_cfg) : 32'(irq_cfg));
    endtask

    // Leave s_axis_tvalid high on return so back-to-back requests need no extra edge.
    task automatic send_request(input logic [FIELD_W-1:0] raw, input logic tick,
                                input logic [FIELD_W-1:0] rmask, input bit typed,
                                input t_panel want);
        t_panel predicted;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, rmask, tick, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_panel(raw, tick, rmask);
        expected_panels.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_panels.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_panel seen;
        t_panel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata;
            if (expected_panels.size() == 0) begin
                mismatches++;
                $display("%0t: result %h with no request outstanding", $time, seen);
            end else begin
                want = expected_panels.pop_front();
                check_field("debounced_levels", want.levels, seen.levels);
                check_field("new_presses", want.got, seen.got);
                check_field("irq_requests", want.irq, seen.irq);
                panels_checked++;
                if (seen.irq != 0)
                    irq_panels++;
            end
        end
    end

    // Receiver pacing: random stalls in changing densities, plus long hold-offs
    // that let the block fill up while requests keep coming.
    initial begin : sink_pacing
        int stall_pct;
        int hold_next;
        stall_pct = 0;
        hold_next = 300;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 199) == 0)
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    default: stall_pct = 35;
                endcase
            if (panels_checked >= hold_next) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_next += 800;
                holds_done++;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_plan_row          opening_plan [$];
        int unsigned        lockout_plan [PHASES];
        int unsigned        tick_plan [PHASES];
        int unsigned        gap_plan [PHASES];
        logic [FIELD_W-1:0] raw_now;
        logic [FIELD_W-1:0] raw;
        logic [FIELD_W-1:0] rmask;
        logic               tick;
        logic [31:0]        irq_value;
        logic [31:0]        lockout_value;

        lockout_plan = '{0, 1, 3, 1000, 0, 0, 100};
        tick_plan    = '{50, 80, 30, 100, 10, 60, 90};
        gap_plan     = '{0, 20, 10, 30, 5, 40, 15};

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        mismatches     = 0;
        requests_sent  = 0;
        panels_checked = 0;
        irq_panels     = 0;
        reg_writes     = 0;
        holds_done     = 0;
        send_gap_pct   = 0;
        lockout_cfg    = LOCKOUT_RESET;
        irq_cfg        = IRQ_MASK_RESET;
        deb_levels     = '0;
        press_held     = '0;
        for (int i = 0; i < FIELD_W; i++)
            lock_left[i] = '0;

        opening_plan = '{
            // reset defaults: lockout 100, irq mask 0xC302
            req_row(16'h0000, 1'b0, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000),
            req_row(16'h00FF, 1'b0, 16'h0000, 1, 16'h00FF, 16'h0000, 16'h0002),
            req_row(16'h0000, 1'b1, 16'h000F, 1, 16'h00FF, 16'h000F, 16'h0000),
            req_row(16'h0000, 1'b0, 16'hFFFF, 1, 16'h00FF, 16'h00F0, 16'h0000),
            // zero lockout: one tick unlocks, and the countdown comes before the compare
            reg_row(sdel_pkg::REG_LOCKOUT, 32'd0),
            reg_row(sdel_pkg::REG_IRQ_MASK, 32'h0000_FFFF),
            req_row(16'hFF00, 1'b0, 16'h0000, 1, 16'hFFFF, 16'h0000, 16'hFF00),
            req_row(16'h0000, 1'b1, 16'hFF00, 1, 16'h00FF, 16'h0000, 16'h0000),
            req_row(16'hFF00, 1'b0, 16'hFFFF, 1, 16'h00FF, 16'h0000, 16'h0000),
            req_row(16'hFF00, 1'b1, 16'hFFFF, 1, 16'hFFFF, 16'hFF00, 16'hFF00),
            // top lockout: reload must hold at the counter maximum, not wrap
            reg_row(sdel_pkg::REG_LOCKOUT, 32'd1023),
            reg_row(sdel_pkg::REG_IRQ_MASK, 32'h0000_0000),
            req_row(16'h0000, 1'b1, 16'hFFFF, 1, 16'h00FF, 16'h0000, 16'h0000),
            req_row(16'hFF00, 1'b1, 16'hFFFF, 1, 16'h00FF, 16'h0000, 16'h0000),
            reg_row(sdel_pkg::REG_LOCKOUT, 32'd1022),
            reg_row(sdel_pkg::REG_IRQ_MASK, 32'h0000_8001),
            req_row(16'hA5A5, 1'b1, 16'h5A5A, 0, '0, '0, '0),
            req_row(16'hFFFF, 1'b0, 16'h0001, 0, '0, '0, '0),
            req_row(16'h0000, 1'b1, 16'h8000, 0, '0, '0, '0),
            req_row(16'h1234, 1'b1, 16'hFFFF, 0, '0, '0, '0)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_reg(sdel_pkg::REG_LOCKOUT, 32'(LOCKOUT_RESET));
        read_reg(sdel_pkg::REG_IRQ_MASK, 32'(IRQ_MASK_RESET));

        foreach (opening_plan[n]) begin
            if (opening_plan[n].kind == ROW_REG) begin
                settle();
                write_reg(opening_plan[n].idx, opening_plan[n].value);
            end else begin
                send_request(opening_plan[n].raw, opening_plan[n].tick, opening_plan[n].rmask,
                             opening_plan[n].typed, opening_plan[n].want);
            end
        end

        raw_now = 16'h1234;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            lockout_value = (p == 5) ? $urandom_range(0, 12) : lockout_plan[p];
            case (p)
                0:       irq_value = 32'h0000_FFFF;
                2:       irq_value = 32'h0000_0000;
                6:       irq_value = 32'(IRQ_MASK_RESET);
                default: irq_value = {16'h0000, 16'($urandom)};
            endcase
            write_reg(sdel_pkg::REG_LOCKOUT, lockout_value);
            write_reg(sdel_pkg::REG_IRQ_MASK, irq_value);
            send_gap_pct = gap_plan[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold steady, bounce a few switches, or glitch once
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: raw = raw_now;
                    5, 6, 7: begin
                        raw_now = raw_now ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
                        raw     = raw_now;
                    end
                    default: raw = raw_now ^ 16'($urandom);
                endcase
                tick = ($urandom_range(0, 99) < tick_plan[p]);
                case ($urandom_range(0, 9))
                    0, 1:    rmask = '1;
                    2, 3:    rmask = '0;
                    4:       rmask = 16'(1) << $urandom_range(0, FIELD_W - 1);
                    default: rmask = 16'($urandom);
                endcase
                send_request(raw, tick, rmask, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d requests under %0d register writes, lockout 0 to 1023",
                 requests_sent, reg_writes);
        $display("%0d results checked, %0d with interrupt requests, %0d long output hold-offs",
                 panels_checked, irq_panels, holds_done);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
